// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Operation codes, status codes and the control struct between submodules.
// No dependencies.
package deq_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_FRONT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic    valid;
    logic    pop_ok;
    status_e status;
  } res_t;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
// Ring pointer and count control for the double-ended queue.
// Computes RAM addresses, updates front pointer and count, registers status.
// Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  func_e                      func_i,
  output logic                       we_o,
  output logic [$clog2(DEPTH)-1:0]   waddr_o,
  output logic [$clog2(DEPTH)-1:0]   raddr_o,
  output res_t                       res_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  res_t          res_q, res_d;
  logic [CW-1:0] cnt_res_q, cnt_res_d;

  logic          full, empty;
  logic [SW-1:0] back_sum, last_sum;
  logic [AW-1:0] back_slot, last_slot, front_dec, front_inc;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // ring index wrap: sums stay below twice the depth
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign last_sum  = back_sum - SW'(1);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  always_comb begin
    front_d        = front_q;
    count_d        = count_q;
    we_o           = 1'b0;
    waddr_o        = back_slot;
    raddr_o        = front_q;
    res_d.valid    = start_i;
    res_d.pop_ok   = 1'b0;
    res_d.status   = ST_DONE;
    if (start_i) begin
      unique case (func_i)
        OP_PUSH_BACK: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = back_slot;
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            raddr_o      = last_slot;
            res_d.pop_ok = 1'b1;
            count_d      = count_q - CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = front_dec;
            front_d = front_dec;
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            raddr_o      = front_q;
            front_d      = front_inc;
            res_d.pop_ok = 1'b1;
            count_d      = count_q - CW'(1);
          end
        end
        default: begin
          res_d.status = ST_DONE;
        end
      endcase
    end
    cnt_res_d = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      res_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_res_q <= cnt_res_d;
  end

  assign res_o   = res_q;
  assign count_o = cnt_res_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: ring control plus one word RAM.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
//   channel   handshake           payload
//   command   start / busy        func_i, push_word_i
//   result    done_o (strobe)     popped_word_o, status_o, element_count_o
//
// one item per cycle; its result strobes in the cycle after acceptance
// busy is always low: a pop reads the RAM in its accept cycle and the
// registered read data forms the result, a push writes in its accept cycle
// reset clears front pointer and count; stored words need no clearing
// results cannot be stalled
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [WORD_W-1:0]  push_word_i,
  output logic               done_o,
  output logic [WORD_W-1:0]  popped_word_o,
  output logic [1:0]         status_o,
  output logic [COUNT_W-1:0] element_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] rdata;
  res_t              res;
  logic [CW-1:0]     count;

  assign busy = 1'b0;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start & ~busy),
    .func_i  (func_e'(func_i)),
    .we_o    (we),
    .waddr_o (waddr),
    .raddr_o (raddr),
    .res_o   (res),
    .count_o (count)
  );

  deq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (push_word_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign done_o          = res.valid;
  assign popped_word_o   = res.pop_ok ? rdata : '0;
  assign status_o        = res.status;
  assign element_count_o = COUNT_W'(count);

endmodule

// ===== verif/double_ended_queue_test.sv =====
// Self-checking testbench for the double-ended queue: directed and random
// pushes and pops at both ends, checked against a ring-buffer mirror.
// Depends on deq_pkg and double_ended_queue.
module double_ended_queue_test import deq_pkg::*;;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned STALL_MAX  = 1000;
  localparam int unsigned DRAIN_WAIT = 10;

  typedef struct {
    logic [WORD_W-1:0]  word;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  // mirror of the ring: head index, fill level and expected outcomes
  class deque_mirror;
    logic [WORD_W-1:0] ring [DEPTH];
    int unsigned head;
    int unsigned fill;
    outcome_t pending_outcomes [$];
    int unsigned mismatches;
    int unsigned items;
    int unsigned results;
    int unsigned full_refusals;
    int unsigned empty_refusals;
    int unsigned peak_fill;

    function void note_command(func_e f, logic [WORD_W-1:0] w);
      outcome_t o;
      o.word   = '0;
      o.status = ST_DONE;
      case (f)
        OP_PUSH_BACK: begin
          if (fill == DEPTH) begin
            o.status = ST_FULL;
          end else begin
            ring[(head + fill) % DEPTH] = w;
            fill++;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) begin
            o.status = ST_EMPTY;
          end else begin
            o.word = ring[(head + fill - 1) % DEPTH];
            fill--;
          end
        end
        OP_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            o.status = ST_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = w;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            o.status = ST_EMPTY;
          end else begin
            o.word = ring[head];
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
      endcase
      o.count = COUNT_W'(fill);
      if (o.status == ST_FULL) full_refusals++;
      if (o.status == ST_EMPTY) empty_refusals++;
      if (fill > peak_fill) peak_fill = fill;
      items++;
      pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("mismatch on result %0d: %s got %h want %h", results, field, got, want);
      mismatches++;
    endtask

    task check_outcome(logic [WORD_W-1:0] popped, logic [1:0] status,
                       logic [COUNT_W-1:0] count);
      outcome_t o;
      results++;
      if (pending_outcomes.size() == 0) begin
        report("unexpected result", popped, '0);
      end else begin
        o = pending_outcomes[0];
        pending_outcomes.delete(0);
        if (popped !== o.word) report("popped_word", popped, o.word);
        if (status !== 2'(o.status)) report("status", WORD_W'(status), WORD_W'(o.status));
        if (count !== o.count) report("element_count", WORD_W'(count), WORD_W'(o.count));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         func_i;
  logic [WORD_W-1:0]  push_word_i;
  logic               done_o;
  logic [WORD_W-1:0]  popped_word_o;
  logic [1:0]         status_o;
  logic [COUNT_W-1:0] element_count_o;

  deque_mirror sb = new();
  int unsigned gap_pct;
  int unsigned quiet_cycles;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .push_word_i     (push_word_i),
    .done_o          (done_o),
    .popped_word_o   (popped_word_o),
    .status_o        (status_o),
    .element_count_o (element_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (start && !busy) begin
        sb.note_command(func_e'(func_i), push_word_i);
        quiet_cycles = 0;
      end
      if (done_o) begin
        sb.check_outcome(popped_word_o, status_o, element_count_o);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_MAX) begin
        $display("watchdog: no item accepted for %0d cycles", STALL_MAX);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic issue_command(func_e f, logic [WORD_W-1:0] w);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= f;
    push_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic issue_random_run(int unsigned n, int unsigned push_pct);
    func_e             f;
    logic [WORD_W-1:0] w;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct) begin
        f = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        f = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      case ($urandom_range(7))
        0:       w = '0;
        1:       w = '1;
        default: w = {$urandom, $urandom};
      endcase
      issue_command(f, w);
    end
  endtask

  initial begin
    int unsigned gap_list [4];
    int unsigned bias_list [3];
    gap_list  = '{0, 48, 16, 0};
    bias_list = '{80, 20, 50};
    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = OP_PUSH_BACK;
    push_word_i  = '0;
    gap_pct      = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pops on empty, extreme words, wrap of the head below zero, order checks
    issue_command(OP_POP_BACK,   '1);
    issue_command(OP_POP_FRONT,  64'h0123_4567_89ab_cdef);
    issue_command(OP_PUSH_BACK,  '1);
    issue_command(OP_PUSH_FRONT, '0);
    issue_command(OP_PUSH_BACK,  64'h8000_0000_0000_0001);
    issue_command(OP_PUSH_FRONT, 64'h5555_5555_5555_5555);
    issue_command(OP_PUSH_BACK,  64'haaaa_aaaa_aaaa_aaaa);
    issue_command(OP_POP_FRONT,  '1);
    issue_command(OP_POP_BACK,   '1);
    issue_command(OP_POP_FRONT,  '0);
    issue_command(OP_POP_BACK,   '0);
    issue_command(OP_POP_BACK,   64'hdead_beef_dead_beef);
    issue_command(OP_POP_FRONT,  '0);
    issue_command(OP_PUSH_FRONT, 64'h0123_4567_89ab_cdef);
    issue_command(OP_POP_FRONT,  '0);
    issue_command(OP_PUSH_BACK,  64'h7fff_ffff_ffff_fffe);
    issue_command(OP_POP_FRONT,  '0);
    issue_command(OP_PUSH_BACK,  64'h0000_0000_0000_0007);
    issue_command(OP_POP_BACK,   '0);

    // fill to full, drain to empty and mixed runs under each gap setting
    foreach (gap_list[g]) begin
      gap_pct = gap_list[g];
      foreach (bias_list[b]) issue_random_run(150, bias_list[b]);
    end
    start <= 1'b0;

    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    while (sb.pending_outcomes.size() != 0) begin
      sb.pending_outcomes.delete(0);
      sb.report("missing result", '0, '0);
    end

    $display("covered %0d items and %0d results, peak fill %0d of %0d",
             sb.items, sb.results, sb.peak_fill, DEPTH);
    $display("refused pushes when full: %0d, refused pops when empty: %0d",
             sb.full_refusals, sb.empty_refusals);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
verif/double_ended_queue_test.sv
